[sv/hfc_pkg.sv]
// Package for the humidity fan controller: shared types, register indexes,
// mode codes and fixed constants. No dependencies.
package hfc_pkg;

    localparam int RH_W      = 10;
    localparam int TEMP_W    = 8;
    localparam int CNT_W     = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 10;
    localparam int IN_DATA_W = 24;
    localparam int OUT_DATA_W = 8;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_RH_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_TEMP     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_RUN      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_S  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REFRESH_S    = 3'd4;

    // Mode codes as seen on the result beat
    localparam logic [1:0] MODE_AUTO     = 2'd0;
    localparam logic [1:0] MODE_ON       = 2'd1;
    localparam logic [1:0] MODE_OFF      = 2'd2;
    localparam logic [1:0] MODE_SETTINGS = 2'd3;

    // Request kinds carried on tuser
    localparam logic REQ_TICK   = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    // Register reset values
    localparam logic [RH_W-1:0]          RST_RH_THRESHOLD = 10'd450;
    localparam logic signed [TEMP_W-1:0] RST_MIN_TEMP     = 8'sd18;
    localparam logic [CNT_W-1:0]         RST_MIN_RUN      = 8'd60;
    localparam logic [CNT_W-1:0]         RST_TICKS_PER_S  = 8'd32;
    localparam logic [CNT_W-1:0]         RST_REFRESH_S    = 8'd6;

    // Button debounce: press flagged on the second held tick, then the
    // count jumps here so that it wraps back to one after 17 more ticks.
    localparam logic [CNT_W-1:0] BTN_PRESS_COUNT  = 8'd1;
    localparam logic [CNT_W-1:0] BTN_REPEAT_LOAD  = 8'd240;

    typedef struct packed {
        logic [RH_W-1:0]          rh_threshold_code;
        logic signed [TEMP_W-1:0] min_temp_c;
        logic [CNT_W-1:0]         min_run_seconds;
        logic [CNT_W-1:0]         ticks_per_second;
        logic [CNT_W-1:0]         refresh_seconds;
    } cfg_t;

    typedef struct packed {
        logic                     req_type;
        logic                     button_pressed;
        logic [RH_W-1:0]          rh_code;
        logic signed [TEMP_W-1:0] temp_celsius;
        logic                     temp_check_on;
    } item_t;

    typedef struct packed {
        logic       fan_on;
        logic       led_on;
        logic [1:0] mode;
        logic       refresh_request;
    } result_t;

endpackage

[sv/humidity_fan_controller_unit.sv]
// Top level of the humidity fan controller: stream ports, input register,
// result register. Depends on hfc_pkg, hfc_cfg_regs and hfc_ctrl.
//
//  Channel   Direction  Handshake                      Carries
//  s_axis    in         s_axis_tvalid / s_axis_tready  one tick or sample beat
//  m_axis    out        m_axis_tvalid / m_axis_tready  one result beat per input beat
//  cfg       in         cfg_we (no back-pressure)      register index and data
//
// One beat is accepted per cycle when the output side keeps up; a result
// is offered once its input beat has passed the input register and the
// combinational control update into the result register.
// Reset (rst_n low) clears both pipeline valids and loads the control state
// and registers with their defaults.
// A stall on m_axis holds the result register; the input register still
// takes one more beat, then s_axis_tready drops until the result moves.
module humidity_fan_controller_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [0] button_pressed, [10:1] rh_code, [18:11] temp_celsius,
    // [19] temp_check_on, [23:20] zero
    input  logic [hfc_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // [0] req_type
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [0] fan_on, [1] led_on, [3:2] mode, [4] refresh_request, [7:5] zero
    output logic [hfc_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input  logic                            cfg_we,
    input  logic [hfc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [hfc_pkg::CFG_W-1:0]       cfg_data
);

    hfc_pkg::cfg_t    cfg;
    hfc_pkg::item_t   item_reg;
    hfc_pkg::result_t result;
    hfc_pkg::result_t out_reg;
    logic             in_valid_reg, in_valid_next;
    logic             out_valid_reg, out_valid_next;
    logic             advance;
    logic             accept;

    // Advance the held beat when the result register is free or draining
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign in_valid_next  = accept || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the input beat; payload needs no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.req_type       <= s_axis_tuser;
            item_reg.button_pressed <= s_axis_tdata[0];
            item_reg.rh_code        <= s_axis_tdata[10:1];
            item_reg.temp_celsius   <= s_axis_tdata[18:11];
            item_reg.temp_check_on  <= s_axis_tdata[19];
        end
    end

    // Hold the result until the sink takes it
    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= result;
    end

    hfc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    hfc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (item_reg),
        .cfg    (cfg),
        .result (result)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_reg.refresh_request, out_reg.mode,
                            out_reg.led_on, out_reg.fan_on};

`ifndef SYNTHESIS
    // A held input beat moves on whenever the result register can take it
    a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !out_valid_reg |-> advance)
        else $error("held beat not advanced into empty result register");

    // The LED never lights with the fan stopped
    a_led_needs_fan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.led_on |-> out_reg.fan_on)
        else $error("LED lit with fan stopped");

    // A stalled result keeps its register and blocks the held beat
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_axis_tready |-> !advance)
        else $error("result register overwritten during stall");
`endif

endmodule

[sv/hfc_cfg_regs.sv]
// Configuration register bank of the humidity fan controller.
// Depends on hfc_pkg.
module hfc_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [hfc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hfc_pkg::CFG_W-1:0]      cfg_data,
    output hfc_pkg::cfg_t                  cfg
);

    hfc_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rh_threshold_code <= hfc_pkg::RST_RH_THRESHOLD;
            cfg_reg.min_temp_c        <= hfc_pkg::RST_MIN_TEMP;
            cfg_reg.min_run_seconds   <= hfc_pkg::RST_MIN_RUN;
            cfg_reg.ticks_per_second  <= hfc_pkg::RST_TICKS_PER_S;
            cfg_reg.refresh_seconds   <= hfc_pkg::RST_REFRESH_S;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                hfc_pkg::REG_RH_THRESHOLD: cfg_reg.rh_threshold_code <= cfg_data;
                hfc_pkg::REG_MIN_TEMP:     cfg_reg.min_temp_c        <= cfg_data[7:0];
                hfc_pkg::REG_MIN_RUN:      cfg_reg.min_run_seconds   <= cfg_data[7:0];
                hfc_pkg::REG_TICKS_PER_S:  cfg_reg.ticks_per_second  <= cfg_data[7:0];
                hfc_pkg::REG_REFRESH_S:    cfg_reg.refresh_seconds   <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[sv/hfc_ctrl.sv]
// Control state of the humidity fan controller and its one-pass update
// for a tick or a sample beat. Depends on hfc_pkg.
module hfc_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  hfc_pkg::item_t   item,
    input  hfc_pkg::cfg_t    cfg,
    output hfc_pkg::result_t result
);

    logic [hfc_pkg::CNT_W-1:0] tick_count_reg, tick_count_next;
    logic [hfc_pkg::CNT_W-1:0] refresh_count_reg, refresh_count_next;
    logic [hfc_pkg::CNT_W-1:0] run_seconds_reg, run_seconds_next;
    logic [hfc_pkg::CNT_W-1:0] button_count_reg, button_count_next;
    logic [1:0]                mode_reg, mode_next;
    logic may_stop_reg, may_stop_next;
    logic fan_reg, fan_next;
    logic press_pending_reg, press_pending_next;
    logic blink_reg, blink_next;
    logic refresh_pending_reg, refresh_pending_next;
    logic req_out;

    logic [hfc_pkg::CNT_W-1:0] tps_eff, rps_eff;
    logic                      sec_end, refresh_end, rh_high, temp_low;
    logic [1:0]                mode_step;

    assign tps_eff = (cfg.ticks_per_second == '0) ? 8'd1 : cfg.ticks_per_second;
    assign rps_eff = (cfg.refresh_seconds == '0) ? 8'd1 : cfg.refresh_seconds;
    assign sec_end = ({1'b0, tick_count_reg} + 9'd1) >= {1'b0, tps_eff};
    assign refresh_end = ({1'b0, refresh_count_reg} + 9'd1) >= {1'b0, rps_eff};
    assign rh_high = (item.rh_code != '0) && (item.rh_code >= cfg.rh_threshold_code);
    assign temp_low = item.temp_check_on && (item.temp_celsius < cfg.min_temp_c);
    assign mode_step = (mode_reg == hfc_pkg::MODE_SETTINGS) ? hfc_pkg::MODE_AUTO
                                                            : mode_reg + 2'd1;

    always_comb
    begin
        tick_count_next      = tick_count_reg;
        refresh_count_next   = refresh_count_reg;
        run_seconds_next     = run_seconds_reg;
        button_count_next    = button_count_reg;
        mode_next            = mode_reg;
        may_stop_next        = may_stop_reg;
        fan_next             = fan_reg;
        press_pending_next   = press_pending_reg;
        blink_next           = blink_reg;
        refresh_pending_next = refresh_pending_reg;
        req_out              = 1'b0;

        if (item.req_type == hfc_pkg::REQ_TICK)
        begin
            if (sec_end)
            begin
                tick_count_next = '0;
                if (refresh_end)
                begin
                    refresh_count_next   = '0;
                    refresh_pending_next = 1'b1;
                end
                else
                begin
                    refresh_count_next = refresh_count_reg + 8'd1;
                end
                if (mode_reg == hfc_pkg::MODE_AUTO && fan_reg && !may_stop_reg)
                begin
                    run_seconds_next = run_seconds_reg + 8'd1;
                    if (run_seconds_reg == cfg.min_run_seconds)
                    begin
                        may_stop_next        = 1'b1;
                        refresh_pending_next = 1'b1;
                    end
                end
                else
                begin
                    run_seconds_next = '0;
                end
                if (fan_reg)
                    blink_next = !blink_reg;
            end
            else
            begin
                tick_count_next = tick_count_reg + 8'd1;
            end

            if (item.button_pressed)
            begin
                if (button_count_reg == hfc_pkg::BTN_PRESS_COUNT)
                begin
                    press_pending_next = 1'b1;
                    button_count_next  = hfc_pkg::BTN_REPEAT_LOAD;
                end
                else
                begin
                    button_count_next = button_count_reg + 8'd1;
                end
            end
            else
            begin
                button_count_next = '0;
            end
        end
        else
        begin
            req_out              = refresh_pending_reg;
            refresh_pending_next = 1'b0;
            if (press_pending_reg)
            begin
                press_pending_next   = 1'b0;
                refresh_pending_next = 1'b1;
                case (mode_step)
                    hfc_pkg::MODE_ON:
                    begin
                        mode_next       = hfc_pkg::MODE_ON;
                        fan_next        = 1'b1;
                        blink_next      = 1'b1;
                        tick_count_next = '0;
                    end
                    hfc_pkg::MODE_OFF:
                    begin
                        mode_next = hfc_pkg::MODE_OFF;
                        fan_next  = 1'b0;
                    end
                    default:
                    begin
                        // auto, and settings falling straight back to auto
                        mode_next       = hfc_pkg::MODE_AUTO;
                        tick_count_next = '0;
                    end
                endcase
            end

            if (mode_next == hfc_pkg::MODE_AUTO)
            begin
                if (rh_high)
                begin
                    if (!temp_low)
                    begin
                        if (!fan_next)
                        begin
                            fan_next      = 1'b1;
                            may_stop_next = 1'b0;
                            blink_next    = 1'b0;
                        end
                        run_seconds_next = '0;
                    end
                end
                else if (may_stop_next && fan_next)
                begin
                    fan_next      = 1'b0;
                    may_stop_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg      <= '0;
            refresh_count_reg   <= '0;
            run_seconds_reg     <= '0;
            button_count_reg    <= '0;
            mode_reg            <= hfc_pkg::MODE_AUTO;
            may_stop_reg        <= 1'b0;
            fan_reg             <= 1'b0;
            press_pending_reg   <= 1'b0;
            blink_reg           <= 1'b0;
            refresh_pending_reg <= 1'b1;
        end
        else if (step)
        begin
            tick_count_reg      <= tick_count_next;
            refresh_count_reg   <= refresh_count_next;
            run_seconds_reg     <= run_seconds_next;
            button_count_reg    <= button_count_next;
            mode_reg            <= mode_next;
            may_stop_reg        <= may_stop_next;
            fan_reg             <= fan_next;
            press_pending_reg   <= press_pending_next;
            blink_reg           <= blink_next;
            refresh_pending_reg <= refresh_pending_next;
        end
    end

    assign result.fan_on          = fan_next;
    assign result.led_on          = fan_next & blink_next;
    assign result.mode            = mode_next;
    assign result.refresh_request = req_out;

`ifndef SYNTHESIS
    // Settings is never held: it falls back to auto in the same pass
    a_no_settings_hold: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg != hfc_pkg::MODE_SETTINGS)
        else $error("mode register holds settings");

    // A sample with no press pending clears the refresh request
    a_sample_clears_refresh: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.req_type == hfc_pkg::REQ_SAMPLE && !press_pending_reg
        |=> !refresh_pending_reg)
        else $error("refresh request survived a sample");

    // A released button tick resets the debounce count
    a_release_clears_btn: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.req_type == hfc_pkg::REQ_TICK && !item.button_pressed
        |=> button_count_reg == '0)
        else $error("debounce count not cleared on release");

    // The run counter only moves on a second boundary or a sample
    a_run_stable_mid_second: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.req_type == hfc_pkg::REQ_TICK && !sec_end
        |=> $stable(run_seconds_reg))
        else $error("run counter moved inside a second");
`endif

endmodule

[tb/sv/tb_top.sv]
// Self-checking bench for humidity_fan_controller_unit: streams tick and sample
// beats, predicts every status beat in a behavioural copy of the controller
// and compares it field by field. Depends on hfc_pkg and the RTL only.
module tb_top;
    import hfc_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int LONG_HOLD    = 300;
    localparam int SETTLE       = 8;
    localparam int MAX_GAP      = 18;
    localparam int REPORT_MAX   = 10;
    localparam int TEMP_LO      = -40;
    localparam int TEMP_HI      = 125;
    localparam int RH_MAX       = (1 << RH_W) - 1;
    localparam int IDX_MAX      = (1 << CFG_IDX_W) - 1;
    // First index past the register file; writes there must be ignored
    localparam int REG_SPARE_LO = int'(REG_REFRESH_S) + 1;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // [0] button_pressed, [10:1] rh_code, [18:11] temp_celsius,
    // [19] temp_check_on, [23:20] zero
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    // [0] req_type
    logic                  s_axis_tuser  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [0] fan_on, [1] led_on, [3:2] mode, [4] refresh_request, [7:5] zero
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_W-1:0]      cfg_data      = '0;

    humidity_fan_controller_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Behavioural copy of the controller: registers and control state
    // ------------------------------------------------------------------
    cfg_t             shadow_cfg;
    logic [CNT_W-1:0] ctl_ticks;
    logic [CNT_W-1:0] ctl_refresh_cnt;
    logic [CNT_W-1:0] ctl_run_secs;
    logic [CNT_W-1:0] ctl_btn_cnt;
    logic [1:0]       ctl_mode;
    logic             ctl_may_stop;
    logic             ctl_fan;
    logic             ctl_press;
    logic             ctl_blink;
    logic             ctl_refresh_due;

    // Bench bookkeeping
    item_t   pending_beats[$];   // beats waiting for the driver
    result_t status_due[$];      // predicted status beats, oldest first
    item_t   offered;            // beat currently presented on s_axis
    result_t got_status;
    result_t want_status;
    logic    beat_taken    = 1'b0;
    int      beats_pushed  = 0;
    int      beats_taken   = 0;
    int      mismatch_count = 0;
    int      cycle_count   = 0;
    int      src_odds      = 0;  // 1-in-N chance of an idle burst, 0 for none
    int      sink_odds     = 0;
    int      src_wait      = 0;
    int      sink_wait     = 0;
    int      hold_requests = 0;
    int      hold_served   = 0;

    function automatic void ctl_reset();
        shadow_cfg.rh_threshold_code = RST_RH_THRESHOLD;
        shadow_cfg.min_temp_c        = RST_MIN_TEMP;
        shadow_cfg.min_run_seconds   = RST_MIN_RUN;
        shadow_cfg.ticks_per_second  = RST_TICKS_PER_S;
        shadow_cfg.refresh_seconds   = RST_REFRESH_S;
        ctl_ticks       = '0;
        ctl_refresh_cnt = '0;
        ctl_run_secs    = '0;
        ctl_btn_cnt     = '0;
        ctl_mode        = MODE_AUTO;
        ctl_may_stop    = 1'b0;
        ctl_fan         = 1'b0;
        ctl_press       = 1'b0;
        ctl_blink       = 1'b0;
        ctl_refresh_due = 1'b1;
    endfunction

    function automatic void ctl_write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        case (idx)
            REG_RH_THRESHOLD: shadow_cfg.rh_threshold_code = data[RH_W-1:0];
            REG_MIN_TEMP:     shadow_cfg.min_temp_c        = data[TEMP_W-1:0];
            REG_MIN_RUN:      shadow_cfg.min_run_seconds   = data[CNT_W-1:0];
            REG_TICKS_PER_S:  shadow_cfg.ticks_per_second  = data[CNT_W-1:0];
            REG_REFRESH_S:    shadow_cfg.refresh_seconds   = data[CNT_W-1:0];
            default:          ;
        endcase
    endfunction

    // One elapsed second: refresh period, minimum-run count, LED blink
    function automatic void ctl_second();
        int period;
        period = (shadow_cfg.refresh_seconds == '0) ? 1 : int'(shadow_cfg.refresh_seconds);
        if (int'(ctl_refresh_cnt) + 1 >= period)
        begin
            ctl_refresh_cnt = '0;
            ctl_refresh_due = 1'b1;
        end
        else
            ctl_refresh_cnt = ctl_refresh_cnt + 1'b1;
        if (ctl_mode == MODE_AUTO && ctl_fan && !ctl_may_stop)
        begin
            if (ctl_run_secs == shadow_cfg.min_run_seconds)
            begin
                ctl_may_stop    = 1'b1;
                ctl_refresh_due = 1'b1;
            end
            ctl_run_secs = ctl_run_secs + 1'b1;
        end
        else
            ctl_run_secs = '0;
        if (ctl_fan)
            ctl_blink = !ctl_blink;
    endfunction

    function automatic void ctl_tick(logic held);
        int per_second;
        per_second = (shadow_cfg.ticks_per_second == '0) ? 1 : int'(shadow_cfg.ticks_per_second);
        if (int'(ctl_ticks) + 1 >= per_second)
        begin
            ctl_ticks = '0;
            ctl_second();
        end
        else
            ctl_ticks = ctl_ticks + 1'b1;
        // Debounce: flag a press on the second held tick, then auto-repeat
        if (held)
        begin
            if (ctl_btn_cnt == BTN_PRESS_COUNT)
            begin
                ctl_press   = 1'b1;
                ctl_btn_cnt = BTN_REPEAT_LOAD;
            end
            else
                ctl_btn_cnt = ctl_btn_cnt + 1'b1;
        end
        else
            ctl_btn_cnt = '0;
    endfunction

    function automatic void ctl_sample(item_t it);
        logic humid;
        if (ctl_press)
        begin
            ctl_mode        = (ctl_mode == MODE_SETTINGS) ? MODE_AUTO : ctl_mode + 2'd1;
            ctl_press       = 1'b0;
            ctl_refresh_due = 1'b1;
            if (ctl_mode == MODE_ON)
            begin
                ctl_fan   = 1'b1;
                ctl_blink = 1'b1;
                ctl_ticks = '0;
            end
            else if (ctl_mode == MODE_OFF)
                ctl_fan = 1'b0;
            else
            begin
                // settings falls straight back to auto
                ctl_ticks = '0;
                ctl_mode  = MODE_AUTO;
            end
        end
        if (ctl_mode != MODE_AUTO)
            return;
        humid = (it.rh_code != '0) && (it.rh_code >= shadow_cfg.rh_threshold_code);
        if (humid)
        begin
            if (it.temp_check_on && ($signed(it.temp_celsius) < $signed(shadow_cfg.min_temp_c)))
                return;
            if (!ctl_fan)
            begin
                ctl_fan      = 1'b1;
                ctl_may_stop = 1'b0;
                ctl_blink    = 1'b0;
            end
            ctl_run_secs = '0;
        end
        else if (ctl_may_stop && ctl_fan)
        begin
            ctl_fan      = 1'b0;
            ctl_may_stop = 1'b0;
        end
    endfunction

    // Advance the copy by one accepted beat and return the status it must produce
    function automatic result_t predict_status(item_t it);
        result_t r;
        r.refresh_request = 1'b0;
        if (it.req_type == REQ_SAMPLE)
        begin
            r.refresh_request = ctl_refresh_due;
            ctl_refresh_due   = 1'b0;
            ctl_sample(it);
        end
        else
            ctl_tick(it.button_pressed);
        r.fan_on = ctl_fan;
        r.led_on = ctl_fan & ctl_blink;
        r.mode   = ctl_mode;
        return r;
    endfunction

    function automatic void note_error(string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("%0t: %s", $time, msg);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus builders: push beats onto the driver's queue
    // ------------------------------------------------------------------
    function automatic int pick_temp();
        int lo;
        lo = $signed(shadow_cfg.min_temp_c);
        case ($urandom_range(3, 0))
            0:       return lo;
            1:       return (lo > TEMP_LO) ? lo - 1 : TEMP_LO;
            default: return int'($urandom_range(TEMP_HI - TEMP_LO, 0)) + TEMP_LO;
        endcase
    endfunction

    function automatic int humid_rh();
        int thr;
        thr = shadow_cfg.rh_threshold_code;
        if ($urandom_range(3, 0) == 0)
            return (thr == 0) ? 1 : thr;
        return $urandom_range(RH_MAX, (thr == 0) ? 1 : thr);
    endfunction

    function automatic int dry_rh();
        int thr;
        thr = shadow_cfg.rh_threshold_code;
        // zero is out of range and never counts as humid
        if (thr <= 1 || $urandom_range(3, 0) == 0)
            return 0;
        if ($urandom_range(2, 0) == 0)
            return thr - 1;
        return $urandom_range(thr - 1, 1);
    endfunction

    function automatic int pick_rh();
        case ($urandom_range(5, 0))
            0:       return 0;
            1:       return RH_MAX;
            2:       return humid_rh();
            3:       return dry_rh();
            default: return $urandom_range(RH_MAX, 0);
        endcase
    endfunction

    function automatic void queue_tick(logic held);
        item_t it;
        it.req_type       = REQ_TICK;
        it.button_pressed = held;
        // sample fields ride along as noise on a tick
        it.rh_code        = RH_W'($urandom_range(RH_MAX, 0));
        it.temp_celsius   = TEMP_W'(pick_temp());
        it.temp_check_on  = 1'($urandom_range(1, 0));
        pending_beats.push_back(it);
        beats_pushed++;
    endfunction

    function automatic void queue_sample(int rh, int temp, logic chk);
        item_t it;
        it.req_type       = REQ_SAMPLE;
        it.button_pressed = 1'($urandom_range(1, 0));
        it.rh_code        = RH_W'(rh);
        it.temp_celsius   = TEMP_W'(temp);
        it.temp_check_on  = chk;
        pending_beats.push_back(it);
        beats_pushed++;
    endfunction

    function automatic int pick_hold();
        case ($urandom_range(6, 0))
            0:       return 1;   // too short to register
            1:       return 2;
            2:       return 3;
            3:       return 19;  // just short of the first repeat
            4:       return 20;  // first auto-repeat
            5:       return 38;  // second auto-repeat
            default: return $urandom_range(45, 1);
        endcase
    endfunction

    // One short scenario with random content
    function automatic void add_episode();
        int n;
        case ($urandom_range(9, 0))
            0, 1, 2, 3:
            begin
                // time passes, with an occasional stray button level and sample
                n = $urandom_range(12, 1);
                repeat (n)
                begin
                    queue_tick($urandom_range(9, 0) == 0);
                    if ($urandom_range(2, 0) == 0)
                        queue_sample(pick_rh(), pick_temp(), 1'($urandom_range(1, 0)));
                end
            end
            4, 5:
            begin
                // button held, released, then the sample that applies it
                n = pick_hold();
                repeat (n) queue_tick(1'b1);
                queue_tick(1'b0);
                n = $urandom_range(2, 1);
                repeat (n) queue_sample(pick_rh(), pick_temp(), 1'($urandom_range(1, 0)));
            end
            6, 7:
            begin
                n = $urandom_range(4, 1);
                repeat (n) queue_sample(humid_rh(), pick_temp(), 1'($urandom_range(1, 0)));
            end
            8:
            begin
                n = $urandom_range(4, 1);
                repeat (n) queue_sample(dry_rh(), pick_temp(), 1'($urandom_range(1, 0)));
            end
            default:
            begin
                n = $urandom_range(6, 1);
                repeat (n)
                begin
                    if ($urandom_range(1, 0) == 0)
                        queue_tick(1'($urandom_range(1, 0)));
                    else
                        queue_sample($urandom_range(RH_MAX, 0), pick_temp(),
                                     1'($urandom_range(1, 0)));
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Register writes and phase control, all from the stimulus process
    // ------------------------------------------------------------------
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        ctl_write_reg(idx, data);
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // 8-bit value with random upper bits, which the register must drop
    function automatic logic [CFG_W-1:0] with_junk(int v);
        logic [CFG_W-1:0] junk;
        junk = CFG_W'($urandom);
        return {junk[CFG_W-1:CNT_W], CNT_W'(v)};
    endfunction

    task automatic set_config(int thr, int min_temp, int min_run, int tps, int refresh);
        write_reg(REG_RH_THRESHOLD, CFG_W'(thr));
        write_reg(REG_MIN_TEMP,     with_junk(min_temp));
        write_reg(REG_MIN_RUN,      with_junk(min_run));
        write_reg(REG_TICKS_PER_S,  with_junk(tps));
        write_reg(REG_REFRESH_S,    with_junk(refresh));
        // an index past the register file must change nothing
        write_reg(CFG_IDX_W'($urandom_range(IDX_MAX, REG_SPARE_LO)), CFG_W'($urandom));
    endtask

    task automatic random_config();
        set_config($urandom_range(700, 200), int'($urandom_range(TEMP_HI - TEMP_LO, 0)) + TEMP_LO,
                   $urandom_range(6, 0), $urandom_range(4, 1), $urandom_range(5, 1));
    endtask

    // Hold the sender until every queued beat has gone in and every status is back
    task automatic drain();
        while (beats_taken != beats_pushed || status_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic run_phase(int budget, int s_odds, int r_odds, bit long_hold);
        int stop_at;
        src_odds  = s_odds;
        sink_odds = r_odds;
        stop_at   = beats_pushed + budget;
        while (beats_pushed < stop_at)
            add_episode();
        // stall the result side for a long stretch while beats keep coming
        if (long_hold)
            hold_requests++;
        drain();
    endtask

    // ------------------------------------------------------------------
    // Driver: present the next beat at the falling edge, with idle bursts
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || beat_taken))
        begin
            if (src_wait > 0)
            begin
                src_wait--;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_beats.size() != 0)
            begin
                offered = pending_beats.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= IN_DATA_W'({offered.temp_check_on, offered.temp_celsius,
                                             offered.rh_code, offered.button_pressed});
                s_axis_tuser  <= offered.req_type;
                if (src_odds != 0 && $urandom_range(src_odds - 1, 0) == 0)
                    src_wait = $urandom_range(MAX_GAP, 1);
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Receiver: tready with idle bursts and the occasional long hold-off
    always @(negedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            sink_wait   = LONG_HOLD;
        end
        if (sink_wait > 0)
        begin
            sink_wait--;
            m_axis_tready <= 1'b0;
        end
        else if (sink_odds != 0 && $urandom_range(sink_odds - 1, 0) == 0)
        begin
            sink_wait = $urandom_range(MAX_GAP, 1) - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Monitor: predict on every input beat, check every status beat
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        beat_taken = rst_n && s_axis_tvalid && s_axis_tready;
        if (beat_taken)
        begin
            status_due.push_back(predict_status(offered));
            beats_taken++;
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_status.fan_on          = m_axis_tdata[0];
            got_status.led_on          = m_axis_tdata[1];
            got_status.mode            = m_axis_tdata[3:2];
            got_status.refresh_request = m_axis_tdata[4];
            if (status_due.size() == 0)
                note_error($sformatf("status beat with none expected: data %h", m_axis_tdata));
            else
            begin
                want_status = status_due.pop_front();
                if (got_status !== want_status)
                    note_error($sformatf(
                        "status mismatch: want fan %0b led %0b mode %0d refresh %0b, %s",
                        want_status.fan_on, want_status.led_on, want_status.mode,
                        want_status.refresh_request,
                        $sformatf("got fan %0b led %0b mode %0d refresh %0b",
                                  got_status.fan_on, got_status.led_on, got_status.mode,
                                  got_status.refresh_request)));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------
    initial
    begin
        ctl_reset();
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part at reset register values (threshold 450, min temp 18)
        src_odds  = 4;
        sink_odds = 4;
        queue_sample(0, 20, 1'b0);          // out-of-range humidity, first refresh
        queue_sample(RH_MAX, TEMP_LO, 1'b1); // humid but too cold: inhibited
        queue_sample(449, TEMP_HI, 1'b1);   // just below threshold
        queue_sample(450, 18, 1'b1);        // at threshold and at min temp: start
        queue_sample(RH_MAX, 17, 1'b1);     // inhibit while running changes nothing
        queue_tick(1'b1);
        queue_tick(1'b1);                   // press flagged on second held tick
        queue_tick(1'b0);
        queue_sample(0, 0, 1'b0);           // auto -> on
        queue_tick(1'b1);
        queue_tick(1'b1);
        queue_tick(1'b0);
        queue_sample(500, TEMP_HI, 1'b0);   // on -> off
        queue_tick(1'b1);
        queue_tick(1'b1);
        queue_sample(1, TEMP_LO, 1'b1);     // off -> settings -> auto, dry
        queue_tick(1'b0);
        queue_sample(RH_MAX, TEMP_HI, 1'b0);
        queue_sample(1, 20, 1'b0);
        drain();

        // Low extremes: every non-zero code is humid, one-tick seconds
        set_config(0, TEMP_LO, 0, 1, 1);
        run_phase(100, 6, 6, 1'b0);

        // High extremes
        set_config(RH_MAX, TEMP_HI, 255, 255, 255);
        run_phase(60, 4, 10, 1'b0);

        // Zero seconds settings act as one; long hold-off on the result side
        set_config($urandom_range(700, 200), 10, $urandom_range(3, 0), 0, 0);
        run_phase(80, 10, 4, 1'b1);

        for (int p = 0; p < 4; p++)
        begin
            random_config();
            run_phase(110, (p == 1) ? 3 : 8, (p == 2) ? 3 : 12, p == 1);
        end

        // Closing stretch at full rate on both sides
        random_config();
        run_phase(120, 0, 0, 1'b0);

        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[files.f]
sv/hfc_pkg.sv
sv/hfc_cfg_regs.sv
sv/hfc_ctrl.sv
sv/humidity_fan_controller_unit.sv
tb/sv/tb_top.sv
